@@ hdl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg: shared types, constants and helpers for the baro compensation block
// Holds the calibration record, register indexes and output saturation.
// ----------------------------------------------------------------------------
package bsc_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_OVERSAMPLING   = 3'd0,
		REG_CAL_A_SIGNED   = 3'd1,
		REG_CAL_A_UNSIGNED = 3'd2,
		REG_CAL_B_PAIR     = 3'd3,
		REG_CAL_M_TRIPLE   = 3'd4
	} reg_index_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 48;

	// Calibration words as the datapath sees them.
	typedef struct packed {
		logic [1:0]  oss;
		logic [15:0] ac1;
		logic [15:0] ac2;
		logic [15:0] ac3;
		logic [15:0] ac4;
		logic [15:0] ac5;
		logic [15:0] ac6;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] mc;
		logic [15:0] md;
	} cal_t;

	localparam logic [1:0]  OSS_RESET     = 2'd1;
	localparam logic [3:0]  UP_SHIFT_BASE = 4'd8;
	localparam logic [31:0] B5_OFFSET     = 32'd4000;
	localparam logic [31:0] X3_BIAS       = 32'd32768;
	localparam logic [15:0] PRESS_SCALE   = 16'd50000;
	localparam logic [31:0] P_COEF_SQ     = 32'd3038;
	localparam logic [31:0] P_COEF_LIN    = 32'd7357;
	localparam logic [31:0] P_OFFSET      = 32'd3791;

	// Widths of the two dividers and the raw pressure after shifting.
	localparam int TDIV_NW = 27;
	localparam int TDIV_DW = 32;
	localparam int PDIV_NW = 32;
	localparam int PDIV_DW = 32;
	localparam int UP_W    = 19;

	localparam logic signed [31:0] TEMP_MIN = -32'sd4096;
	localparam logic signed [31:0] TEMP_MAX = 32'sd4095;
	localparam logic signed [31:0] PRES_MAX = 32'sd262143;

	// Sign-extend a 16-bit calibration word to the 32-bit datapath.
	function automatic logic [31:0] sx16(logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// Clamp a 32-bit signed value to the 13-bit temperature range.
	function automatic logic [12:0] sat_temp(logic [31:0] v);
		logic signed [31:0] s;
		s = signed'(v);
		if (s < TEMP_MIN) begin
			return TEMP_MIN[12:0];
		end else if (s > TEMP_MAX) begin
			return TEMP_MAX[12:0];
		end
		return v[12:0];
	endfunction

	// Clamp a 32-bit signed value to the 18-bit pressure range.
	function automatic logic [17:0] sat_pres(logic [31:0] v);
		logic signed [31:0] s;
		s = signed'(v);
		if (s < 0) begin
			return 18'd0;
		end else if (s > PRES_MAX) begin
			return PRES_MAX[17:0];
		end
		return v[17:0];
	endfunction

endpackage

@@ hdl/bsc_cfg.sv @@
// ----------------------------------------------------------------------------
// bsc_cfg: configuration registers
// Holds oversampling and calibration words and unpacks them into cal_t.
// ----------------------------------------------------------------------------
module bsc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bsc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output bsc_pkg::cal_t                    cal
);
	import bsc_pkg::*;

	logic [1:0]  oss_q;
	logic [47:0] cal_a_s_q;
	logic [47:0] cal_a_u_q;
	logic [31:0] cal_b_q;
	logic [47:0] cal_m_q;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q     <= OSS_RESET;
			cal_a_s_q <= '0;
			cal_a_u_q <= '0;
			cal_b_q   <= '0;
			cal_m_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_OVERSAMPLING:   oss_q     <= cfg_data[1:0];
				REG_CAL_A_SIGNED:   cal_a_s_q <= cfg_data;
				REG_CAL_A_UNSIGNED: cal_a_u_q <= cfg_data;
				REG_CAL_B_PAIR:     cal_b_q   <= cfg_data[31:0];
				REG_CAL_M_TRIPLE:   cal_m_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the words; MB in the top of the M triple is not used.
	assign cal.oss = oss_q;
	assign cal.ac1 = cal_a_s_q[47:32];
	assign cal.ac2 = cal_a_s_q[31:16];
	assign cal.ac3 = cal_a_s_q[15:0];
	assign cal.ac4 = cal_a_u_q[47:32];
	assign cal.ac5 = cal_a_u_q[31:16];
	assign cal.ac6 = cal_a_u_q[15:0];
	assign cal.b1  = cal_b_q[31:16];
	assign cal.b2  = cal_b_q[15:0];
	assign cal.mc  = cal_m_q[31:16];
	assign cal.md  = cal_m_q[15:0];

endmodule

@@ hdl/bsc_udiv.sv @@
// ----------------------------------------------------------------------------
// bsc_udiv: pipelined unsigned restoring divider
// One quotient bit per stage, with a sideband word that travels alongside.
// ----------------------------------------------------------------------------
module bsc_udiv #(
	parameter int NW = bsc_pkg::PDIV_NW,
	parameter int DW = bsc_pkg::PDIV_DW,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [NW-1:0] quotient,
	output logic [SW-1:0] side_out
);
	import bsc_pkg::*;

	logic [NW:0]   vld_s;
	logic [DW-1:0] rem_s  [NW+1];
	logic [NW-1:0] dvd_s  [NW+1];
	logic [DW-1:0] dvs_s  [NW+1];
	logic [NW-1:0] quo_s  [NW+1];
	logic [SW-1:0] side_s [NW+1];

	// Stage zero is the input itself.
	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign dvd_s[0]  = dividend;
	assign dvs_s[0]  = divisor;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0]   trial;
		logic [DW+1:0] diff;
		logic          ge;

		// Bring down the next dividend bit and try the subtraction.
		assign trial = {rem_s[k], dvd_s[k][NW-1]};
		assign diff  = {1'b0, trial} - {2'b00, dvs_s[k]};
		assign ge    = !diff[DW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				dvd_s[k+1]  <= dvd_s[k] << 1;
				dvs_s[k+1]  <= dvs_s[k];
				quo_s[k+1]  <= {quo_s[k][NW-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[NW];
	assign quotient = quo_s[NW];
	assign side_out = side_s[NW];

endmodule

@@ hdl/baro_sensor_compensation.sv @@
// ----------------------------------------------------------------------------
// baro_sensor_compensation: barometric temperature and pressure compensation
// Deep pipeline from raw sensor words to tenths of a degree and pascals.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    raw_temp, raw_pressure
//  output    out        out_valid / out_stall  temp_tenths, pressure_pa,
//                                              divide_error
//  config    in         cfg_wr_en              cfg_index, cfg_data
//
// One beat enters per cycle while out_stall does not hold the output; the two
// bit-per-stage dividers (27 and 32 stages) make up most of the pipeline.
// A stall on the output freezes every stage at once, so nothing is lost or
// repeated; in_stall follows out_stall while the output stage holds a beat.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [bsc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [15:0]                     raw_temp,
	input  logic [23:0]                     raw_pressure,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [12:0]              temp_tenths,
	output logic [17:0]                     pressure_pa,
	output logic                            divide_error
);
	import bsc_pkg::*;

	localparam int TSW = 32 + UP_W + 2;
	localparam int PSW = 13 + 3;

	cal_t cal;
	logic en;

	bsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	// Whole-pipeline advance: hold everything while the output beat waits.
	logic v_s13;
	assign en       = !(v_s13 && out_stall);
	assign in_stall = !en;

	// Stage 1: temperature offset and pressure oversampling shift.
	logic            v_s1;
	logic [16:0]     dt_s1;
	logic [UP_W-1:0] up_s1;
	logic [3:0]      up_shift;
	assign up_shift = UP_SHIFT_BASE - {2'b00, cal.oss};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dt_s1 <= {1'b0, raw_temp} - {1'b0, cal.ac6};
			up_s1 <= UP_W'(raw_pressure >> up_shift);
		end
	end

	// Stage 2: X1 = ((UT - AC6) * AC5) >> 15.
	logic            v_s2;
	logic [31:0]     x1_s2;
	logic [UP_W-1:0] up_s2;
	logic [31:0]     t_prod;
	assign t_prod = {{15{dt_s1[16]}}, dt_s1} * {16'd0, cal.ac5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2 <= $signed(t_prod) >>> 15;
			up_s2 <= up_s1;
		end
	end

	// Stage 3: divisor X1 + MD and numerator MC * 2048 as sign and magnitude.
	logic               v_s3;
	logic [TDIV_NW-1:0] nmag_s3;
	logic [31:0]        dmag_s3;
	logic               qneg_s3;
	logic               dz_s3;
	logic [31:0]        x1_s3;
	logic [UP_W-1:0]    up_s3;
	logic [31:0]        den;
	logic [31:0]        num;
	logic [31:0]        num_mag;
	assign den     = x1_s2 + sx16(cal.md);
	assign num     = sx16(cal.mc) << 11;
	assign num_mag = cal.mc[15] ? (32'd0 - num) : num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmag_s3 <= num_mag[TDIV_NW-1:0];
			dmag_s3 <= den[31] ? (32'd0 - den) : den;
			qneg_s3 <= cal.mc[15] ^ den[31];
			dz_s3   <= (den == 32'd0);
			x1_s3   <= x1_s2;
			up_s3   <= up_s2;
		end
	end

	// Temperature divider: X2 magnitude = |MC * 2048| / |X1 + MD|.
	logic               v_d1;
	logic [TDIV_NW-1:0] q1;
	logic [TSW-1:0]     side1;

	bsc_udiv #(
		.NW (TDIV_NW),
		.DW (TDIV_DW),
		.SW (TSW)
	) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s3),
		.dividend (nmag_s3),
		.divisor  (dmag_s3),
		.side_in  ({x1_s3, up_s3, qneg_s3, dz_s3}),
		.out_vld  (v_d1),
		.quotient (q1),
		.side_out (side1)
	);

	// Stage 4: B5, temperature output and B6.
	logic            v_s4;
	logic [12:0]     temp_s4;
	logic [31:0]     b6_s4;
	logic [UP_W-1:0] up_s4;
	logic            errt_s4;
	logic [31:0]     d1_x1;
	logic            d1_qneg;
	logic            d1_dz;
	logic [31:0]     q1_ext;
	logic [31:0]     b5;
	logic [31:0]     b5_r;
	assign d1_x1   = side1[TSW-1 -: 32];
	assign d1_qneg = side1[1];
	assign d1_dz   = side1[0];
	assign q1_ext  = {{(32-TDIV_NW){1'b0}}, q1};
	assign b5      = d1_x1 + (d1_qneg ? (32'd0 - q1_ext) : q1_ext);
	assign b5_r    = $signed(b5 + 32'd8) >>> 4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s4 <= d1_dz ? 13'd0 : sat_temp(b5_r);
			b6_s4   <= b5 - B5_OFFSET;
			up_s4   <= side1[UP_W+1:2];
			errt_s4 <= d1_dz;
		end
	end

	// Stage 5: B6 squared, AC2 * B6 and AC3 * B6.
	logic            v_s5;
	logic [31:0]     sqf_s5;
	logic [31:0]     ac2b6_s5;
	logic [31:0]     ac3b6_s5;
	logic [12:0]     temp_s5;
	logic [UP_W-1:0] up_s5;
	logic            errt_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqf_s5   <= b6_s4 * b6_s4;
			ac2b6_s5 <= sx16(cal.ac2) * b6_s4;
			ac3b6_s5 <= sx16(cal.ac3) * b6_s4;
			temp_s5  <= temp_s4;
			up_s5    <= up_s4;
			errt_s5  <= errt_s4;
		end
	end

	// Stage 6: B2 and B1 times the scaled square.
	logic            v_s6;
	logic [31:0]     b2sq_s6;
	logic [31:0]     b1sq_s6;
	logic [31:0]     x2a_s6;
	logic [31:0]     x1c_s6;
	logic [12:0]     temp_s6;
	logic [UP_W-1:0] up_s6;
	logic            errt_s6;
	logic [31:0]     sq;
	assign sq = $signed(sqf_s5) >>> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b2sq_s6 <= sx16(cal.b2) * sq;
			b1sq_s6 <= sx16(cal.b1) * sq;
			x2a_s6  <= $signed(ac2b6_s5) >>> 11;
			x1c_s6  <= $signed(ac3b6_s5) >>> 13;
			temp_s6 <= temp_s5;
			up_s6   <= up_s5;
			errt_s6 <= errt_s5;
		end
	end

	// Stage 7: B3 and the biased X3 that feeds B4.
	logic            v_s7;
	logic [31:0]     b3_s7;
	logic [31:0]     x3p_s7;
	logic [12:0]     temp_s7;
	logic [UP_W-1:0] up_s7;
	logic            errt_s7;
	logic [31:0]     x3;
	logic [31:0]     b3_pre;
	logic [31:0]     x3b_pre;
	logic [31:0]     x3b;
	assign x3      = 32'($signed(b2sq_s6) >>> 11) + x2a_s6;
	assign b3_pre  = (((sx16(cal.ac1) << 2) + x3) << cal.oss) + 32'd2;
	assign x3b_pre = x1c_s6 + 32'($signed(b1sq_s6) >>> 16) + 32'd2;
	assign x3b     = $signed(x3b_pre) >>> 2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b3_s7   <= $signed(b3_pre) >>> 2;
			x3p_s7  <= x3b + X3_BIAS;
			temp_s7 <= temp_s6;
			up_s7   <= up_s6;
			errt_s7 <= errt_s6;
		end
	end

	// Stage 8: B4 and UP - B3.
	logic        v_s8;
	logic [31:0] b4_s8;
	logic [31:0] diff_s8;
	logic [12:0] temp_s8;
	logic        errt_s8;
	logic [31:0] b4_prod;
	assign b4_prod = {16'd0, cal.ac4} * x3p_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b4_s8   <= b4_prod >> 15;
			diff_s8 <= {{(32-UP_W){1'b0}}, up_s7} - b3_s7;
			temp_s8 <= temp_s7;
			errt_s8 <= errt_s7;
		end
	end

	// Stage 9: B7 = (UP - B3) * (50000 >> oss).
	logic        v_s9;
	logic [31:0] b7_s9;
	logic [31:0] b4_s9;
	logic [12:0] temp_s9;
	logic        errt_s9;
	logic [15:0] scale;
	assign scale = PRESS_SCALE >> cal.oss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b7_s9   <= diff_s8 * {16'd0, scale};
			b4_s9   <= b4_s8;
			temp_s9 <= temp_s8;
			errt_s9 <= errt_s8;
		end
	end

	// Pressure divider: a small B7 is doubled before dividing, a large one after.
	logic               v_d2;
	logic [PDIV_NW-1:0] q2;
	logic [PSW-1:0]     side2;
	logic [31:0]        p_dvd;
	assign p_dvd = b7_s9[31] ? b7_s9 : (b7_s9 << 1);

	bsc_udiv #(
		.NW (PDIV_NW),
		.DW (PDIV_DW),
		.SW (PSW)
	) u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s9),
		.dividend (p_dvd),
		.divisor  (b4_s9),
		.side_in  ({temp_s9, errt_s9, b7_s9[31], (b4_s9 == 32'd0)}),
		.out_vld  (v_d2),
		.quotient (q2),
		.side_out (side2)
	);

	// Stage 10: pressure estimate P.
	logic        v_s10;
	logic [31:0] p_s10;
	logic [12:0] temp_s10;
	logic        errt_s10;
	logic        b4z_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s10    <= side2[1] ? (q2 << 1) : q2;
			temp_s10 <= side2[PSW-1 -: 13];
			errt_s10 <= side2[2];
			b4z_s10  <= side2[0];
		end
	end

	// Stage 11: (P >> 8) squared and -7357 * P.
	logic        v_s11;
	logic [31:0] x1sq_s11;
	logic [31:0] m7_s11;
	logic [31:0] p_s11;
	logic [12:0] temp_s11;
	logic        errt_s11;
	logic        b4z_s11;
	logic [31:0] p_hi;
	assign p_hi = $signed(p_s10) >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1sq_s11 <= p_hi * p_hi;
			m7_s11   <= 32'd0 - (P_COEF_LIN * p_s10);
			p_s11    <= p_s10;
			temp_s11 <= temp_s10;
			errt_s11 <= errt_s10;
			b4z_s11  <= b4z_s10;
		end
	end

	// Stage 12: square term times 3038.
	logic        v_s12;
	logic [31:0] x1m_s12;
	logic [31:0] x2b_s12;
	logic [31:0] p_s12;
	logic [12:0] temp_s12;
	logic        errt_s12;
	logic        b4z_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1m_s12  <= x1sq_s11 * P_COEF_SQ;
			x2b_s12  <= $signed(m7_s11) >>> 16;
			p_s12    <= p_s11;
			temp_s12 <= temp_s11;
			errt_s12 <= errt_s11;
			b4z_s12  <= b4z_s11;
		end
	end

	// Stage 13: final correction, saturation and the output register.
	logic [12:0] temp_s13;
	logic [17:0] pres_s13;
	logic        err_s13;
	logic [31:0] corr;
	logic [31:0] pres;
	assign corr = 32'($signed(x1m_s12) >>> 16) + x2b_s12 + P_OFFSET;
	assign pres = p_s12 + 32'($signed(corr) >>> 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s13 <= temp_s12;
			pres_s13 <= (errt_s12 || b4z_s12) ? 18'd0 : sat_pres(pres);
			err_s13  <= errt_s12 || b4z_s12;
		end
	end

	assign out_valid    = v_s13;
	assign temp_tenths  = temp_s13;
	assign pressure_pa  = pres_s13;
	assign divide_error = err_s13;

endmodule
